### rtl/spq_pkg.sv
// shared constants, types and codes of the sorted priority queue
package spq_pkg;

    // store geometry
    localparam int CAPACITY  = 16;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_EXT_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

    // request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // command codes on the input port
    typedef logic [CMD_W-1:0] cmd_t;
    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_LIST   = 2'd2;

    // status codes on the output port
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // decoded operation carried through the queue
    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_LIST
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } req_t;

    // head of the request queue as seen by the back end
    typedef struct packed {
        logic valid;
        req_t req;
    } qhead_t;

    // back end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_LIST
    } bk_state_t;

endpackage

### rtl/spq_front.sv
// front end: accepts requests, decodes commands, drops unused codes
module spq_front (
    input  spq_pkg::cmd_t                     command,
    input  logic signed [spq_pkg::DATA_W-1:0] value,
    input  logic                              in_valid,
    input  logic                              q_full,
    output logic                              in_stall,
    output logic                              push,
    output spq_pkg::req_t                     push_req
);

    logic cmd_known;

    // stall only while the request queue has no room
    assign in_stall = q_full;

    // command decode
    always_comb
    begin
        cmd_known      = 1'b1;
        push_req.value = value;
        push_req.op    = spq_pkg::OP_INSERT;
        unique case (command)
            spq_pkg::CMD_INSERT: push_req.op = spq_pkg::OP_INSERT;
            spq_pkg::CMD_REMOVE: push_req.op = spq_pkg::OP_REMOVE;
            spq_pkg::CMD_LIST:   push_req.op = spq_pkg::OP_LIST;
            default:             cmd_known   = 1'b0;
        endcase
    end

    // unused codes are accepted and silently dropped
    assign push = in_valid && !q_full && cmd_known;

endmodule

### rtl/spq_queue.sv
// short request queue between front end and back end
module spq_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  spq_pkg::req_t   push_req,
    input  logic            pop,
    output spq_pkg::qhead_t head,
    output logic            full
);

    spq_pkg::req_t                   slots_reg [spq_pkg::QDEPTH];
    logic [spq_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [spq_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [spq_pkg::QCNT_W-1:0]      fill_reg, fill_next;

    // status toward both sides
    assign full       = (fill_reg == spq_pkg::QCNT_W'(spq_pkg::QDEPTH));
    assign head.valid = (fill_reg != '0);
    assign head.req   = slots_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == spq_pkg::QPTR_W'(spq_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + spq_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == spq_pkg::QPTR_W'(spq_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + spq_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + spq_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - spq_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

### rtl/spq_back.sv
// back end: sorted cell chain, list sequencer and output register
module spq_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  spq_pkg::qhead_t                    head,
    output logic                               pop,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic signed [spq_pkg::DATA_W-1:0]  data,
    output spq_pkg::status_t                   status,
    output logic                               last,
    output logic [spq_pkg::OCC_W-1:0]          occupancy
);

    logic signed [spq_pkg::DATA_W-1:0] cells_reg  [spq_pkg::CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] cells_next [spq_pkg::CAPACITY];
    logic [spq_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [spq_pkg::CNT_W-1:0]         idx_reg, idx_next;
    spq_pkg::bk_state_t                state_reg, state_next;

    logic                              out_valid_reg, out_valid_next;
    logic signed [spq_pkg::DATA_W-1:0] data_reg, data_next;
    spq_pkg::status_t                  status_reg, status_next;
    logic                              last_reg, last_next;
    logic [spq_pkg::OCC_W-1:0]         occ_reg, occ_next;

    logic                              out_free;
    logic                              take;
    logic                              emit_list;
    logic                              is_full;
    logic                              is_empty;
    logic                              list_end;
    logic [spq_pkg::CAPACITY-1:0]      lt;
    logic [spq_pkg::CNT_EXT_W-1:0]     cnt_ext;

    // handshake and status decode
    assign out_free  = !out_valid_reg || !out_stall;
    assign take      = (state_reg == spq_pkg::BK_IDLE) && head.valid && out_free;
    assign emit_list = (state_reg == spq_pkg::BK_LIST) && out_free;
    assign pop       = take;
    assign is_full   = (count_reg == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign list_end  = (idx_reg == count_reg - spq_pkg::CNT_W'(1));

    // per-cell compare: stored value below the incoming one
    always_comb
    begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
        begin
            lt[i] = (spq_pkg::CNT_W'(i) < count_reg) && (cells_reg[i] < head.req.value);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spq_pkg::BK_IDLE:
            begin
                if (take && head.req.op == spq_pkg::OP_LIST
                    && count_reg > spq_pkg::CNT_W'(1))
                begin
                    state_next = spq_pkg::BK_LIST;
                end
            end
            spq_pkg::BK_LIST:
            begin
                if (emit_list && list_end)
                begin
                    state_next = spq_pkg::BK_IDLE;
                end
            end
            default: state_next = spq_pkg::BK_IDLE;
        endcase
    end

    // cell chain update and result generation
    always_comb
    begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
        end
        count_next  = count_reg;
        idx_next    = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_next   = data_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            data_next      = '0;
            status_next    = spq_pkg::ST_OK;
            last_next      = 1'b1;
            unique case (head.req.op)
                spq_pkg::OP_INSERT:
                begin
                    if (is_full)
                    begin
                        status_next = spq_pkg::ST_FULL;
                    end
                    else
                    begin
                        // cells below the slot hold, the slot takes the value,
                        // cells above it move up by one
                        if (!lt[0])
                        begin
                            cells_next[0] = head.req.value;
                        end
                        for (int i = 1; i < spq_pkg::CAPACITY; i++)
                        begin
                            if (!lt[i])
                            begin
                                cells_next[i] = lt[i-1] ? head.req.value : cells_reg[i-1];
                            end
                        end
                        count_next = count_reg + spq_pkg::CNT_W'(1);
                        data_next  = head.req.value;
                    end
                end
                spq_pkg::OP_REMOVE:
                begin
                    if (is_empty)
                    begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next = cells_reg[0];
                        for (int i = 0; i < spq_pkg::CAPACITY - 1; i++)
                        begin
                            cells_next[i] = cells_reg[i+1];
                        end
                        count_next = count_reg - spq_pkg::CNT_W'(1);
                    end
                end
                spq_pkg::OP_LIST:
                begin
                    if (is_empty)
                    begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        data_next = cells_reg[0];
                        last_next = (count_reg == spq_pkg::CNT_W'(1));
                        idx_next  = spq_pkg::CNT_W'(1);
                    end
                end
                default: status_next = spq_pkg::ST_OK;
            endcase
        end
        else if (emit_list)
        begin
            // one stored value per cycle while listing and the output is not stalled
            out_valid_next = 1'b1;
            data_next      = cells_reg[idx_reg[spq_pkg::IDX_W-1:0]];
            status_next    = spq_pkg::ST_OK;
            last_next      = list_end;
            idx_next       = idx_reg + spq_pkg::CNT_W'(1);
        end
        cnt_ext  = spq_pkg::CNT_EXT_W'(count_next);
        occ_next = cnt_ext[spq_pkg::OCC_W-1:0];
        if (!(take || emit_list))
        begin
            occ_next = occ_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spq_pkg::BK_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // cell chain and result payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < spq_pkg::CAPACITY; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        data_reg   <= data_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        occ_reg    <= occ_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign occupancy = occ_reg;

endmodule

### rtl/sorted_priority_queue.sv
// top level of the sorted priority queue
//
// Keeps up to 16 signed 32-bit values in ascending order in a chain of
// register cells. Each input request carries a command and a value:
// insert places the value ahead of the first stored value that is not
// smaller, remove returns the smallest value, list returns every stored
// value in ascending order. Code 3 is accepted and ignored.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. Requests pass through a two-entry queue to the back end.
// Insert and remove pass the cell chain at one request per cycle while
// no list runs and the receiver does not stall; a list emits the stored
// values in turn (one result when empty) while later requests wait in
// the queue. A request is registered in the queue, then at the output.
// Every result carries status, a last flag and the occupancy after the
// command. While the receiver stalls, the output register holds its result
// and the queue absorbs up to two more requests before in_stall rises.
// Reset empties the store and the queue; no clearing pass is needed.
module sorted_priority_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  spq_pkg::cmd_t                     command,
    input  logic signed [spq_pkg::DATA_W-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [spq_pkg::DATA_W-1:0] data,
    output spq_pkg::status_t                  status,
    output logic                              last,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);

    logic            push;
    spq_pkg::req_t   push_req;
    logic            pop;
    logic            q_full;
    spq_pkg::qhead_t head;

    // request decode
    spq_front u_front (
        .command  (command),
        .value    (value),
        .in_valid (in_valid),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .push_req (push_req)
    );

    // decoupling queue
    spq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .full     (q_full)
    );

    // sorted store and result stage
    spq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .data      (data),
        .status    (status),
        .last      (last),
        .occupancy (occupancy)
    );

endmodule

### rtl/spq_checker.sv
// port-level checks of the sorted priority queue, bound to the top level
module spq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [spq_pkg::DATA_W-1:0] data,
    input logic [spq_pkg::STATUS_W-1:0]      status,
    input logic                              last,
    input logic [spq_pkg::OCC_W-1:0]         occupancy
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(status)
            && $stable(last) && $stable(occupancy))
        else $error("stalled result changed");

    // an error result carries zero data and closes its request
    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != spq_pkg::ST_OK |-> data == '0 && last)
        else $error("error result malformed");

    // empty status only with an empty store
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == spq_pkg::ST_EMPTY |-> occupancy == '0)
        else $error("empty status with stored values");

    // full status only with a full store
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == spq_pkg::ST_FULL
            |-> occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY))
        else $error("full status below capacity");

    // status code is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == spq_pkg::ST_OK || status == spq_pkg::ST_EMPTY
            || status == spq_pkg::ST_FULL)
        else $error("unused status code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data      (data),
    .status    (status),
    .last      (last),
    .occupancy (occupancy)
);

### tb/tb_sorted_priority_queue.sv
// self-checking testbench for the sorted priority queue: directed and random commands
module tb_sorted_priority_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    // command code that the block accepts and ignores
    localparam cmd_t CMD_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 80;
    localparam int SEG_REQUESTS  = 16;

    typedef struct {
        cmd_t                     cmd;
        logic signed [DATA_W-1:0] val;
        int unsigned              gap;
    } req_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic                     last;
        logic [OCC_W-1:0]         occ;
    } result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    cmd_t                     command = CMD_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] data;
    status_t                  status;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;

    // requests waiting for the driver, results waiting for the monitor
    req_item_t                pending_reqs[$];
    result_t                  pending_results[$];
    // sorted contents of the store as predicted
    logic signed [DATA_W-1:0] store_vals[$];

    // handshake flags, set at the rising edge and read at the falling edge
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;

    int unsigned send_wait = 0;
    int unsigned rx_wait = 0;
    int unsigned rx_max_wait = 5;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;

    int fail_count = 0;
    int cycle_count = 0;
    int n_reqs = 0;
    int n_results = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_in_stalled = 0;
    int longest_list = 0;

    sorted_priority_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .status    (status),
        .last      (last),
        .occupancy (occupancy)
    );

    // free running clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t make_result(input logic signed [DATA_W-1:0] d,
                                            input status_t st, input logic lst);
        result_t r;
        r.data   = d;
        r.status = st;
        r.last   = lst;
        r.occ    = OCC_W'(store_vals.size());
        return r;
    endfunction

    // apply one command to the predicted store and queue the results it causes
    task automatic update_sorted_store(input cmd_t cmd, input logic signed [DATA_W-1:0] val);
        int                       pos;
        logic signed [DATA_W-1:0] front;
        pos = 0;
        case (cmd)
            CMD_INSERT:
            begin
                if (store_vals.size() >= CAPACITY)
                begin
                    n_full++;
                    pending_results.push_back(make_result('0, ST_FULL, 1'b1));
                end
                else
                begin
                    // goes ahead of the first value that is not smaller
                    while (pos < store_vals.size() && store_vals[pos] < val)
                        pos++;
                    store_vals.insert(pos, val);
                    pending_results.push_back(make_result(val, ST_OK, 1'b1));
                end
            end
            CMD_REMOVE:
            begin
                if (store_vals.size() == 0)
                begin
                    n_empty++;
                    pending_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end
                else
                begin
                    front = store_vals.pop_front();
                    pending_results.push_back(make_result(front, ST_OK, 1'b1));
                end
            end
            CMD_LIST:
            begin
                if (store_vals.size() == 0)
                begin
                    n_empty++;
                    pending_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end
                else
                begin
                    if (store_vals.size() > longest_list)
                        longest_list = store_vals.size();
                    for (pos = 0; pos < store_vals.size(); pos++)
                        pending_results.push_back(make_result(store_vals[pos], ST_OK,
                                                              pos == store_vals.size() - 1));
                end
            end
            default:
            begin
                // unused code: no state change, no result
            end
        endcase
    endtask

    // check accepted results, then record the accepted request
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            res_taken = out_valid && !out_stall;
            req_taken = in_valid && !in_stall;
            if (in_valid && in_stall)
                n_in_stalled++;
            if (res_taken)
            begin
                n_results++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: data %0d status %0d last %0d occupancy %0d",
                           data, status, last, occupancy);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (data !== want.data)
                    begin
                        $error("data: expected %0d, actual %0d", want.data, data);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, last);
                        fail_count++;
                    end
                    if (occupancy !== want.occ)
                    begin
                        $error("occupancy: expected %0d, actual %0d", want.occ, occupancy);
                        fail_count++;
                    end
                end
            end
            if (req_taken)
            begin
                n_reqs++;
                update_sorted_store(command, value);
            end
        end
    end

    // request driver, fed from the pending queue
    always @(negedge clk)
    begin
        req_item_t item;
        logic      nxt_valid;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (in_valid && req_taken)
                nxt_valid = 1'b0;
            if (!nxt_valid && pending_reqs.size() != 0)
            begin
                if (send_wait < pending_reqs[0].gap)
                    send_wait++;
                else
                begin
                    item = pending_reqs.pop_front();
                    send_wait = 0;
                    command <= item.cmd;
                    value <= item.val;
                    nxt_valid = 1'b1;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // result receiver: random waits per result and an occasional long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (res_taken)
                rx_wait = $urandom_range(0, rx_max_wait);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_priority_queue verification failed");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            4, 5, 6: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_request(input cmd_t cmd, input logic signed [DATA_W-1:0] val,
                                 input int unsigned gap);
        req_item_t item;
        item.cmd = cmd;
        item.val = val;
        item.gap = gap;
        pending_reqs.push_back(item);
    endtask

    task automatic wait_sent();
        while (pending_reqs.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        int   i;
        int   seg;
        int   counted;
        int   ins_pct;
        int   r;
        cmd_t cmd;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, ignored code, fill to capacity
        queue_request(CMD_LIST, '0, $urandom_range(0, 5));
        queue_request(CMD_REMOVE, 32'sh7fff_ffff, $urandom_range(0, 5));
        queue_request(CMD_UNUSED, 32'sh5a5a_a5a5, $urandom_range(0, 5));
        queue_request(CMD_INSERT, 32'sh7fff_ffff, $urandom_range(0, 5));
        queue_request(CMD_INSERT, 32'sh8000_0000, $urandom_range(0, 5));
        queue_request(CMD_INSERT, 0, $urandom_range(0, 5));
        queue_request(CMD_INSERT, -1, $urandom_range(0, 5));
        queue_request(CMD_INSERT, 0, $urandom_range(0, 5));
        queue_request(CMD_LIST, -1, $urandom_range(0, 5));
        queue_request(CMD_REMOVE, '0, $urandom_range(0, 5));
        for (i = 0; i < 12; i++)
            queue_request(CMD_INSERT, pick_value(), $urandom_range(0, 5));
        // store is full here: refused insert, full list, ignored code
        queue_request(CMD_INSERT, 32'sh1234_5678, $urandom_range(0, 5));
        queue_request(CMD_LIST, '0, $urandom_range(0, 5));
        queue_request(CMD_UNUSED, -1, $urandom_range(0, 5));
        wait_drained();

        // long receiver hold-off while requests keep arriving back to back
        hold_req = HOLD_CYCLES;
        queue_request(CMD_LIST, '0, 0);
        for (i = 0; i < 16; i++)
            queue_request($urandom_range(0, 1) ? CMD_INSERT : CMD_REMOVE, pick_value(), 0);
        queue_request(CMD_LIST, '0, 0);
        wait_drained();

        // random segments: fill-heavy, calm drain, fill-heavy, balanced
        for (seg = 0; seg < 4; seg++)
        begin
            case (seg)
                0:       ins_pct = 65;
                1:       ins_pct = 25;
                2:       ins_pct = 75;
                default: ins_pct = 45;
            endcase
            rx_max_wait = (seg == 1) ? 0 : 5;
            counted = 0;
            while (counted < SEG_REQUESTS)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    cmd = CMD_UNUSED;
                else if (r < 15)
                    cmd = CMD_LIST;
                else if ($urandom_range(0, 99) < ins_pct)
                    cmd = CMD_INSERT;
                else
                    cmd = CMD_REMOVE;
                if (cmd != CMD_UNUSED)
                    counted++;
                queue_request(cmd, pick_value(), (seg == 1) ? 0 : $urandom_range(0, 5));
            end
            wait_sent();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests and %0d results, longest list %0d values",
                 n_reqs, n_results, longest_list);
        $display("refused inserts %0d, empty-store results %0d, input stall cycles %0d",
                 n_full, n_empty, n_in_stalled);
        if (fail_count == 0)
            $display("sorted_priority_queue verification clean");
        else
            $display("sorted_priority_queue verification failed");
        $finish;
    end

endmodule

### sorted_priority_queue.f
rtl/spq_pkg.sv
rtl/spq_front.sv
rtl/spq_queue.sv
rtl/spq_back.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
tb/tb_sorted_priority_queue.sv
